[rtl/core/rbj_pkg.sv]
// Shared constants, widths, stage timing and the arctangent table for the
// range/bearing Jacobian pipeline. No dependencies.
`default_nettype none

package rbj_pkg;

  localparam int FRACTION_BITS    = 16;
  localparam int ANGLE_ITERATIONS = 20;

  // field widths
  localparam int TAG_W  = 10;
  localparam int POS_W  = 32;
  localparam int HEAD_W = 19;
  localparam int DIST_W = 33;
  localparam int ANG_W  = 20;
  localparam int JAC_W  = 32;

  localparam int IN_TDATA_W  = 160;
  localparam int OUT_TDATA_W = 200;

  // datapath widths
  localparam int DW      = POS_W + 1;   // signed delta
  localparam int AW      = POS_W + 1;   // delta magnitude
  localparam int S_W     = 2 * AW;      // sum of squares
  localparam int SQ_BITS = S_W / 2;     // root bits, one per stage
  localparam int SQ_RW   = SQ_BITS + 3; // root remainder

  localparam int RQ_FRAC   = 30;
  localparam int DIV_SHIFT = (2 * FRACTION_BITS > 32) ? 2 * FRACTION_BITS : 32;
  localparam int DIV_Q     = DIV_SHIFT + 1;

  localparam int CW        = DW + 4;
  localparam int ZW        = 35;
  localparam int ATAN_FRAC = 30;
  localparam int A_SH      = ATAN_FRAC - FRACTION_BITS;
  localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
  localparam logic [ZW:0] A_HALF = (ZW+1)'(1) << (A_SH - 1);

  localparam logic [29:0] ATAN_TAB [0:30] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
    30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
    30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
    30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
    30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
    30'h00000001
  };

  // stage at which each value sits in its register
  localparam int T_IN  = 1;
  localparam int T_S   = 3;
  localparam int T_R   = T_S + SQ_BITS;
  localparam int T_BQ  = T_S + DIV_Q;
  localparam int T_RQ  = T_R + DIV_Q;
  localparam int T_Z   = T_IN + 1 + ANGLE_ITERATIONS;
  localparam int T_ANG = T_Z + 1;
  localparam int T_END = T_RQ;

  typedef struct packed {
    logic zero;
    logic nx;
    logic ny;
    logic px;
    logic py;
  } flags_t;

endpackage

`default_nettype wire

[rtl/core/range_bearing_observation_jacobian.sv]
// Range/bearing observation model with Jacobian terms for one landmark per
// transaction. Fully pipelined: one landmark enters per cycle; the latency is set
// by the 33-stage square root followed by the 33-stage range divider, while
// the bearing dividers and the CORDIC run beside them. The whole pipeline holds
// when the result is not taken. Depends on rbj_pkg, rbj_sqrt, rbj_div, rbj_cordic.
`default_nettype none

module range_bearing_observation_jacobian import rbj_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // landmark_id, robot_x, robot_y, robot_heading, landmark_x, landmark_y, pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // tag_out, distance, relative_angle, jac_range_x, jac_range_y,
  // jac_bearing_x, jac_bearing_y, zero_distance, clipped, pad
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic adv;

  logic [TAG_W-1:0]         landmark_id;
  logic signed [POS_W-1:0]  robot_x, robot_y, landmark_x, landmark_y;
  logic signed [HEAD_W-1:0] robot_heading;
  logic signed [DW-1:0]     dx_c, dy_c;
  flags_t                   fl_c;

  logic                      vld   [T_IN:T_END];
  logic [TAG_W-1:0]          tag_d [T_IN:T_END];
  flags_t                    fl_d  [T_IN:T_END];
  logic signed [HEAD_W-1:0]  hd_d  [T_IN:T_Z];
  logic [AW-1:0]             ax_d  [T_IN:T_R];
  logic [AW-1:0]             ay_d  [T_IN:T_R];
  logic signed [DW-1:0]      dx1, dy1;
  logic [S_W-1:0]            sqx, sqy, s3;
  logic [SQ_BITS-1:0]        root;
  logic [SQ_BITS-1:0]        r_d   [T_R+1:T_END];
  logic [DIV_Q-1:0]          bqx, bqy, rqx, rqy;
  logic [DIV_Q-1:0]          bqx_d [T_BQ+1:T_END];
  logic [DIV_Q-1:0]          bqy_d [T_BQ+1:T_END];
  logic signed [ZW-1:0]      z_out;
  logic signed [ZW:0]        z_round, ang_full;
  logic [ANG_W-1:0]          ang_d [T_ANG:T_END];

  logic [JAC_W-1:0] jrx_mag, jry_mag, jbx_val, jby_val;
  logic [DIV_Q-1:0] bmx, bmy, limx, limy;
  logic             clpx, clpy;

  logic                     out_vld;
  logic [TAG_W-1:0]         tag_out;
  logic [DIST_W-1:0]        distance;
  logic [ANG_W-1:0]         relative_angle;
  logic [JAC_W-1:0]         jac_range_x, jac_range_y, jac_bearing_x, jac_bearing_y;
  logic                     zero_distance, clipped;

  assign adv      = !out_vld || m_tready;
  assign s_tready = adv;

  assign landmark_id   = s_tdata[9:0];
  assign robot_x       = s_tdata[41:10];
  assign robot_y       = s_tdata[73:42];
  assign robot_heading = s_tdata[92:74];
  assign landmark_x    = s_tdata[124:93];
  assign landmark_y    = s_tdata[156:125];

  assign dx_c = DW'(landmark_x) - DW'(robot_x);
  assign dy_c = DW'(landmark_y) - DW'(robot_y);

  always_comb begin
    fl_c.zero = (dx_c == '0) && (dy_c == '0);
    fl_c.nx   = dx_c[DW-1];
    fl_c.ny   = dy_c[DW-1];
    fl_c.px   = !dx_c[DW-1] && (dx_c != '0);
    fl_c.py   = !dy_c[DW-1] && (dy_c != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = T_IN; k <= T_END; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[T_IN] <= s_tvalid;
      for (int k = T_IN + 1; k <= T_END; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_d[T_IN] <= landmark_id;
      fl_d[T_IN]  <= fl_c;
      hd_d[T_IN]  <= robot_heading;
      ax_d[T_IN]  <= dx_c[DW-1] ? AW'(-dx_c) : AW'(dx_c);
      ay_d[T_IN]  <= dy_c[DW-1] ? AW'(-dy_c) : AW'(dy_c);
      dx1         <= dx_c;
      dy1         <= dy_c;
      for (int k = T_IN + 1; k <= T_END; k++) begin
        tag_d[k] <= tag_d[k-1];
        fl_d[k]  <= fl_d[k-1];
      end
      for (int k = T_IN + 1; k <= T_Z; k++) begin
        hd_d[k] <= hd_d[k-1];
      end
      for (int k = T_IN + 1; k <= T_R; k++) begin
        ax_d[k] <= ax_d[k-1];
        ay_d[k] <= ay_d[k-1];
      end
      sqx <= S_W'(ax_d[T_IN]) * S_W'(ax_d[T_IN]);
      sqy <= S_W'(ay_d[T_IN]) * S_W'(ay_d[T_IN]);
      s3  <= sqx + sqy;
      r_d[T_R+1] <= root;
      for (int k = T_R + 2; k <= T_END; k++) begin
        r_d[k] <= r_d[k-1];
      end
      bqx_d[T_BQ+1] <= bqx;
      bqy_d[T_BQ+1] <= bqy;
      for (int k = T_BQ + 2; k <= T_END; k++) begin
        bqx_d[k] <= bqx_d[k-1];
        bqy_d[k] <= bqy_d[k-1];
      end
      ang_d[T_ANG] <= ang_full[ANG_W-1:0];
      for (int k = T_ANG + 1; k <= T_END; k++) begin
        ang_d[k] <= ang_d[k-1];
      end
    end
  end

  rbj_sqrt u_sqrt (
    .clk    (clk),
    .en     (adv),
    .rad_in (s3),
    .root   (root)
  );

  rbj_div u_bdiv_x (.clk(clk), .en(adv), .num(ax_d[T_S]), .den(s3), .quo(bqx));
  rbj_div u_bdiv_y (.clk(clk), .en(adv), .num(ay_d[T_S]), .den(s3), .quo(bqy));
  rbj_div u_rdiv_x (.clk(clk), .en(adv), .num(ax_d[T_R]), .den(S_W'(root)), .quo(rqx));
  rbj_div u_rdiv_y (.clk(clk), .en(adv), .num(ay_d[T_R]), .den(S_W'(root)), .quo(rqy));

  rbj_cordic u_cordic (
    .clk   (clk),
    .en    (adv),
    .dx    (dx1),
    .dy    (dy1),
    .angle (z_out)
  );

  // round Q2.30 to the output fraction, then take off the heading
  assign z_round  = (ZW+1)'(z_out) + $signed(A_HALF);
  assign ang_full = (z_round >>> A_SH) - (ZW+1)'(hd_d[T_Z]);

  always_comb begin
    jrx_mag = JAC_W'(rqx >> (DIV_SHIFT - RQ_FRAC));
    jry_mag = JAC_W'(rqy >> (DIV_SHIFT - RQ_FRAC));
    bmx     = bqx_d[T_END] >> (DIV_SHIFT - 2 * FRACTION_BITS);
    bmy     = bqy_d[T_END] >> (DIV_SHIFT - 2 * FRACTION_BITS);
    // a positive delta gives a negative term, which reaches one further
    limx    = fl_d[T_END].px ? (DIV_Q'(1) << 31) : ((DIV_Q'(1) << 31) - DIV_Q'(1));
    limy    = fl_d[T_END].py ? (DIV_Q'(1) << 31) : ((DIV_Q'(1) << 31) - DIV_Q'(1));
    clpx    = bmx > limx;
    clpy    = bmy > limy;
    jbx_val = clpx ? JAC_W'(limx) : JAC_W'(bmx);
    jby_val = clpy ? JAC_W'(limy) : JAC_W'(bmy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= vld[T_END];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_out       <= tag_d[T_END];
      zero_distance <= fl_d[T_END].zero;
      if (fl_d[T_END].zero) begin
        distance       <= '0;
        relative_angle <= '0;
        jac_range_x    <= '0;
        jac_range_y    <= '0;
        jac_bearing_x  <= '0;
        jac_bearing_y  <= '0;
        clipped        <= 1'b0;
      end else begin
        distance       <= DIST_W'(r_d[T_END]);
        relative_angle <= ang_d[T_END];
        jac_range_x    <= fl_d[T_END].nx ? -jrx_mag : jrx_mag;
        jac_range_y    <= fl_d[T_END].ny ? -jry_mag : jry_mag;
        jac_bearing_x  <= fl_d[T_END].px ? -jbx_val : jbx_val;
        jac_bearing_y  <= fl_d[T_END].py ? -jby_val : jby_val;
        clipped        <= clpx || clpy;
      end
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {7'b0, clipped, zero_distance, jac_bearing_y, jac_bearing_x,
                     jac_range_y, jac_range_x, relative_angle, distance, tag_out};

  a_zero_clean: assert property (@(posedge clk) disable iff (rst)
    out_vld && zero_distance |-> distance == '0 && !clipped && jac_range_x == '0)
    else $error("zero distance result carries nonzero terms");

  a_dist_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_vld && !zero_distance |-> distance != '0)
    else $error("separated positions gave zero distance");

  a_range_bound: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> ($signed(jac_range_x) <= 32'sd1073741824) &&
                ($signed(jac_range_x) >= -32'sd1073741824))
    else $error("range term out of unit bound");

endmodule

`default_nettype wire

[rtl/core/rbj_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on rbj_pkg.
`default_nettype none

module rbj_sqrt import rbj_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [S_W-1:0]     rad_in,
  output logic [SQ_BITS-1:0] root
);

  logic [SQ_RW-1:0]   rem_q  [SQ_BITS];
  logic [SQ_BITS-1:0] root_q [SQ_BITS];
  logic [S_W-1:0]     rad_q  [SQ_BITS];
  logic [SQ_RW-1:0]   rem_n  [SQ_BITS];
  logic [SQ_BITS-1:0] root_n [SQ_BITS];
  logic [S_W-1:0]     rad_n  [SQ_BITS];
  logic [SQ_RW-1:0]   cur    [SQ_BITS];
  logic [SQ_RW-1:0]   trial  [SQ_BITS];
  logic [SQ_RW-1:0]   prem   [SQ_BITS];
  logic [SQ_BITS-1:0] proot  [SQ_BITS];
  logic [S_W-1:0]     prad   [SQ_BITS];

  always_comb begin
    for (int i = 0; i < SQ_BITS; i++) begin
      if (i == 0) begin
        prem[i]  = '0;
        proot[i] = '0;
        prad[i]  = rad_in;
      end else begin
        prem[i]  = rem_q[i-1];
        proot[i] = root_q[i-1];
        prad[i]  = rad_q[i-1];
      end
      cur[i]   = {prem[i][SQ_RW-3:0], prad[i][S_W-1 -: 2]};
      trial[i] = {1'b0, proot[i], 2'b01};
      if (cur[i] >= trial[i]) begin
        rem_n[i]  = cur[i] - trial[i];
        root_n[i] = {proot[i][SQ_BITS-2:0], 1'b1};
      end else begin
        rem_n[i]  = cur[i];
        root_n[i] = {proot[i][SQ_BITS-2:0], 1'b0};
      end
      rad_n[i] = {prad[i][S_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SQ_BITS; i++) begin
        rem_q[i]  <= rem_n[i];
        root_q[i] <= root_n[i];
        rad_q[i]  <= rad_n[i];
      end
    end
  end

  assign root = root_q[SQ_BITS-1];

endmodule

`default_nettype wire

[rtl/core/rbj_div.sv]
// Pipelined restoring divider: (num << DIV_SHIFT) / den, one quotient bit
// per stage. Depends on rbj_pkg.
`default_nettype none

module rbj_div import rbj_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    num,
  input  logic [S_W-1:0]   den,
  output logic [DIV_Q-1:0] quo
);

  logic [S_W-1:0]   rem_q [DIV_Q];
  logic [S_W-1:0]   den_q [DIV_Q];
  logic [DIV_Q-1:0] quo_q [DIV_Q];
  logic [S_W-1:0]   rem_n [DIV_Q];
  logic [DIV_Q-1:0] quo_n [DIV_Q];
  logic [S_W:0]     cand  [DIV_Q];
  logic [S_W-1:0]   dsel  [DIV_Q];
  logic [DIV_Q-1:0] pquo  [DIV_Q];
  logic             ge    [DIV_Q];

  // numerator bits below the top quotient bit are all zero, so the first
  // stage takes the whole magnitude and later stages shift in zeros
  always_comb begin
    for (int i = 0; i < DIV_Q; i++) begin
      if (i == 0) begin
        cand[i] = (S_W+1)'(num);
        dsel[i] = den;
        pquo[i] = '0;
      end else begin
        cand[i] = {rem_q[i-1], 1'b0};
        dsel[i] = den_q[i-1];
        pquo[i] = quo_q[i-1];
      end
      ge[i] = cand[i] >= {1'b0, dsel[i]};
      if (ge[i]) begin
        rem_n[i] = S_W'(cand[i] - {1'b0, dsel[i]});
      end else begin
        rem_n[i] = cand[i][S_W-1:0];
      end
      quo_n[i] = {pquo[i][DIV_Q-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIV_Q; i++) begin
        rem_q[i] <= rem_n[i];
        den_q[i] <= dsel[i];
        quo_q[i] <= quo_n[i];
      end
    end
  end

  assign quo = quo_q[DIV_Q-1];

endmodule

`default_nettype wire

[rtl/core/rbj_cordic.sv]
// Pipelined vectoring CORDIC giving atan2(dy, dx) in Q2.30.
// Depends on rbj_pkg (arctangent table, widths).
`default_nettype none

module rbj_cordic import rbj_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] dx,
  input  logic signed [DW-1:0] dy,
  output logic signed [ZW-1:0] angle
);

  logic signed [CW-1:0] x_q [ANGLE_ITERATIONS+1];
  logic signed [CW-1:0] y_q [ANGLE_ITERATIONS+1];
  logic signed [ZW-1:0] z_q [ANGLE_ITERATIONS+1];
  logic signed [CW-1:0] x_n [ANGLE_ITERATIONS+1];
  logic signed [CW-1:0] y_n [ANGLE_ITERATIONS+1];
  logic signed [ZW-1:0] z_n [ANGLE_ITERATIONS+1];
  logic signed [CW-1:0] xe, ye;
  logic signed [ZW-1:0] at;

  always_comb begin
    xe = CW'(dx);
    ye = CW'(dy);
    // left half plane: turn by pi first
    if (dx[DW-1]) begin
      x_n[0] = -xe;
      y_n[0] = -ye;
      z_n[0] = dy[DW-1] ? -PI_Q30 : PI_Q30;
    end else begin
      x_n[0] = xe;
      y_n[0] = ye;
      z_n[0] = '0;
    end
    at = '0;
    for (int i = 0; i < ANGLE_ITERATIONS; i++) begin
      at = $signed(ZW'(ATAN_TAB[i]));
      if (!y_q[i][CW-1]) begin
        x_n[i+1] = x_q[i] + (y_q[i] >>> i);
        y_n[i+1] = y_q[i] - (x_q[i] >>> i);
        z_n[i+1] = z_q[i] + at;
      end else begin
        x_n[i+1] = x_q[i] - (y_q[i] >>> i);
        y_n[i+1] = y_q[i] + (x_q[i] >>> i);
        z_n[i+1] = z_q[i] - at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= ANGLE_ITERATIONS; i++) begin
        x_q[i] <= x_n[i];
        y_q[i] <= y_n[i];
        z_q[i] <= z_n[i];
      end
    end
  end

  assign angle = z_q[ANGLE_ITERATIONS];

endmodule

`default_nettype wire
